/* rtl/core/spd_pkg.sv */
`default_nettype none

package spd_pkg;

    // Field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned StatusW = 2;
    localparam int unsigned CfgIdxW = 2;

    // Marker values after reset
    localparam logic [ByteW-1:0] StartMarkerRst = 8'h7E;
    localparam logic [ByteW-1:0] StopMarkerRst  = 8'h7F;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_STOP_MARKER  = 2'd1;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // End-of-frame status codes
    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_BADSUM = 2'd1;
    localparam logic [StatusW-1:0] ST_NOSTOP = 2'd2;

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_SEEK = 6'b000001,
        PH_ID   = 6'b000010,
        PH_SIZE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_SUM  = 6'b010000,
        PH_STOP = 6'b100000
    } t_phase;

endpackage

`default_nettype wire

/* rtl/core/serial_packet_deframer_unit.sv */
`default_nettype none

// Byte-framed packet deframer with an additive checksum.
//
// Input channel (i_in_valid / o_in_stall) carries one received byte per
// request. Frames look like: start marker, id, size, size payload bytes,
// checksum (sum mod 256 of id, size and payload), stop marker.
// Output channel (o_out_valid / i_out_stall) carries at most one result per
// input byte: a payload result for every payload byte (with id, size and
// index), and one end result per frame with status ok, checksum mismatch
// or stop byte missing.
// Throughput: one byte per clock cycle while input stall is low. The parser
// state and the result register both update at the edge that accepts a byte; a result appears
// on the output in the cycle after its byte is accepted.
// A single result register separates the two sides: a new byte is taken
// while the held result is being taken, and input stall rises only while
// a result waits and the receiver stalls.
// Markers are written through the plain write port (index 0 start, index 1
// stop, others ignored) only while idle; the user, not the block, ensures it.
// Reset (synchronous, active low) drops any held result, restores the
// default markers (0x7E start, 0x7F stop) and returns to the start search.
module serial_packet_deframer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [spd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [spd_pkg::ByteW-1:0]   i_cfg_data,
    // input byte channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [spd_pkg::ByteW-1:0]   i_rx_byte,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_kind,
    output logic [spd_pkg::ByteW-1:0]        o_packet_id,
    output logic [spd_pkg::ByteW-1:0]        o_packet_size,
    output logic [spd_pkg::ByteW-1:0]        o_payload_index,
    output logic [spd_pkg::ByteW-1:0]        o_data_byte,
    output logic [spd_pkg::StatusW-1:0]      o_status
);
    import spd_pkg::*;

    // Configuration
    logic [ByteW-1:0] r_start_marker;
    logic [ByteW-1:0] r_stop_marker;

    // Parser state
    t_phase           r_phase,      n_phase;
    logic [ByteW-1:0] r_sum,        n_sum;
    logic [ByteW-1:0] r_index,      n_index;
    logic [ByteW-1:0] r_frame_id,   n_frame_id;
    logic [ByteW-1:0] r_frame_size, n_frame_size;

    // Result register
    logic               r_out_valid;
    logic               r_kind,   n_kind;
    logic [ByteW-1:0]   r_pidx,   n_pidx;
    logic [ByteW-1:0]   r_data,   n_data;
    logic [StatusW-1:0] r_status, n_status;
    logic               n_emit;

    logic             in_accept;
    logic [ByteW-1:0] sum_plus;
    logic [ByteW-1:0] index_plus;

    // Stall only while a result waits and the receiver holds it off.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign sum_plus   = r_sum + i_rx_byte;
    assign index_plus = r_index + 8'd1;

    // Parse one byte: next state and the result it causes, if any.
    always_comb begin
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_index      = r_index;
        n_frame_id   = r_frame_id;
        n_frame_size = r_frame_size;
        n_emit       = 1'b0;
        n_kind       = KIND_DATA;
        n_pidx       = '0;
        n_data       = '0;
        n_status     = ST_OK;
        unique case (r_phase)
            PH_ID: begin
                n_frame_id = i_rx_byte;
                n_sum      = sum_plus;
                n_phase    = PH_SIZE;
            end
            PH_SIZE: begin
                n_frame_size = i_rx_byte;
                n_sum        = sum_plus;
                n_index      = '0;
                // a zero-length frame goes straight to its checksum
                n_phase      = (i_rx_byte == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                n_emit  = 1'b1;
                n_pidx  = r_index;
                n_data  = i_rx_byte;
                n_sum   = sum_plus;
                n_index = index_plus;
                if (index_plus >= r_frame_size) begin
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                if (i_rx_byte != r_sum) begin
                    // checksum mismatch: report and drop back to the search
                    n_emit   = 1'b1;
                    n_kind   = KIND_END;
                    n_status = ST_BADSUM;
                    n_sum    = '0;
                    n_index  = '0;
                    n_phase  = PH_SEEK;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_STOP: begin
                // frame ends whatever the byte; a wrong one flags it
                n_emit   = 1'b1;
                n_kind   = KIND_END;
                n_status = (i_rx_byte == r_stop_marker) ? ST_OK : ST_NOSTOP;
                n_sum    = '0;
                n_index  = '0;
                n_phase  = PH_SEEK;
            end
            default: begin
                // searching for a start byte; everything else is dropped
                if (i_rx_byte == r_start_marker) begin
                    n_sum   = '0;
                    n_index = '0;
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_SEEK;
                end
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= StartMarkerRst;
            r_stop_marker  <= StopMarkerRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: begin
                    r_start_marker <= i_cfg_data;
                end
                CFG_STOP_MARKER: begin
                    r_stop_marker <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Parser state: advance on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEEK;
            r_sum        <= '0;
            r_index      <= '0;
            r_frame_id   <= '0;
            r_frame_size <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_sum        <= n_sum;
            r_index      <= n_index;
            r_frame_id   <= n_frame_id;
            r_frame_size <= n_frame_size;
        end
    end

    // Result valid: set on a new result, clear once the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: id and size come from the frame as updated.
    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_kind   <= n_kind;
            r_pidx   <= n_pidx;
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    logic [ByteW-1:0] r_out_id;
    logic [ByteW-1:0] r_out_size;

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_id   <= n_frame_id;
            r_out_size <= n_frame_size;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_packet_id     = r_out_id;
    assign o_packet_size   = r_out_size;
    assign o_payload_index = r_pidx;
    assign o_data_byte     = r_data;
    assign o_status        = r_status;

`ifndef ASSERT_OFF
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parser phase not one-hot");

    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_frame_size != '0 && r_index < r_frame_size))
        else $error("payload index ran past the frame size");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_DATA) |-> (o_status == ST_OK))
        else $error("payload result carries a nonzero status");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_END) |->
            (o_payload_index == '0 && o_data_byte == '0))
        else $error("end result carries payload fields");

    a_result_to_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_emit && n_kind == KIND_END) |=> (r_phase == PH_SEEK))
        else $error("end result did not return the parser to the search");
`endif

endmodule

`default_nettype wire
